@@ rtl/tsh_pkg.sv @@
// shared types and constants of the taxon state histogram
// no dependencies; imported by every other file of the block except tsh_ram
package tsh_pkg;

  localparam int unsigned MAX_TAXA    = 16;
  localparam int unsigned STATE_SLOTS = 16;
  localparam int unsigned TABLE_DEPTH = MAX_TAXA * STATE_SLOTS;
  localparam int unsigned TAXON_W     = $clog2(MAX_TAXA);
  localparam int unsigned STATE_W     = 4;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SITES_W     = 64;
  localparam int unsigned CLASS_W     = 8;
  localparam int unsigned NUM_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [NUM_W-1:0] ACTIVE_STATES_RST = NUM_W'(4);
  localparam logic [NUM_W-1:0] ACTIVE_TAXA_RST   = NUM_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_STATES = 2'd0,
    REG_ACTIVE_TAXA   = 2'd1,
    REG_SINGLE_CLASS  = 2'd2,
    REG_TARGET_CLASS  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_RD_DATA
  } ctrl_state_e;

  typedef struct packed {
    logic load_item;
    logic clear_all;
    logic taxon_clr;
    logic taxon_inc;
    logic rd_issue_add;
    logic wr_add;
    logic rd_issue_read;
    logic load_out;
  } tsh_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              add_skip;
    logic              last_taxon;
    logic              out_busy;
  } tsh_status_t;

endpackage

@@ rtl/tsh_if.sv @@
// valid/ready channels of the taxon state histogram
// depends on tsh_pkg for field widths
interface tsh_in_if;
  import tsh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [SITES_W-1:0]   site_states;
  logic [CLASS_W-1:0]   site_class;
  logic [COUNT_W-1:0]   weight;
  logic [TAXON_W-1:0]   read_taxon;
  logic [STATE_W-1:0]   read_state;

  modport source (
    output valid, kind, site_states, site_class, weight, read_taxon, read_state,
    input  ready
  );
  modport sink (
    input  valid, kind, site_states, site_class, weight, read_taxon, read_state,
    output ready
  );
endinterface

interface tsh_out_if;
  import tsh_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_value;

  modport source (output valid, count_value, input ready);
  modport sink (input valid, count_value, output ready);
endinterface

@@ rtl/tsh_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module tsh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tsh_datapath.sv @@
// datapath: item and config registers, count table ram, valid bits,
// saturating adder and output register; depends on tsh_pkg, tsh_ram
module tsh_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tsh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [tsh_pkg::KIND_W-1:0]    kind_i,
  input  logic [tsh_pkg::SITES_W-1:0]   site_states_i,
  input  logic [tsh_pkg::CLASS_W-1:0]   site_class_i,
  input  logic [tsh_pkg::COUNT_W-1:0]   weight_i,
  input  logic [tsh_pkg::TAXON_W-1:0]   read_taxon_i,
  input  logic [tsh_pkg::STATE_W-1:0]   read_state_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tsh_pkg::COUNT_W-1:0]   count_value_o,
  input  tsh_pkg::tsh_cmd_t             cmd_i,
  output tsh_pkg::tsh_status_t          status_o
);
  import tsh_pkg::*;

  // config registers
  logic [NUM_W-1:0]   act_states_q;
  logic [NUM_W-1:0]   act_taxa_q;
  logic               single_q;
  logic [CLASS_W-1:0] target_q;

  // item registers
  logic [KIND_W-1:0]  kind_q;
  logic [SITES_W-1:0] states_q;
  logic [CLASS_W-1:0] class_q;
  logic [COUNT_W-1:0] weight_q;
  logic [TAXON_W-1:0] rtaxon_q;
  logic [STATE_W-1:0] rstate_q;

  logic [TAXON_W-1:0]     taxon_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   hit_q;
  logic                   skip_q;
  logic [ADDR_W-1:0]      waddr_q;
  logic                   out_valid_q;
  logic [COUNT_W-1:0]     count_q;

  logic [STATE_W-1:0] code;
  logic               code_ok;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] old_val;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat_val;
  logic               ram_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_states_q <= ACTIVE_STATES_RST;
      act_taxa_q   <= ACTIVE_TAXA_RST;
      single_q     <= 1'b0;
      target_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACTIVE_STATES: act_states_q <= cfg_wdata_i[NUM_W-1:0];
        REG_ACTIVE_TAXA:   act_taxa_q   <= cfg_wdata_i[NUM_W-1:0];
        REG_SINGLE_CLASS:  single_q     <= cfg_wdata_i[0];
        REG_TARGET_CLASS:  target_q     <= cfg_wdata_i[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q   <= kind_i;
      states_q <= site_states_i;
      class_q  <= site_class_i;
      weight_q <= weight_i;
      rtaxon_q <= read_taxon_i;
      rstate_q <= read_state_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taxon_q <= '0;
    end else if (cmd_i.taxon_clr) begin
      taxon_q <= '0;
    end else if (cmd_i.taxon_inc) begin
      taxon_q <= taxon_q + TAXON_W'(1);
    end
  end

  // state code of the current taxon; codes at or above active_states are ambiguous
  assign code    = states_q[taxon_q*STATE_W +: STATE_W];
  assign code_ok = {1'b0, code} < act_states_q;

  assign ram_re    = cmd_i.rd_issue_add | cmd_i.rd_issue_read;
  assign ram_raddr = cmd_i.rd_issue_read ? {rtaxon_q, rstate_q} : {taxon_q, code};

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      hit_q   <= valid_q[ram_raddr];
      skip_q  <= !code_ok;
      waddr_q <= ram_raddr;
    end
  end

  // an entry never written since the last clear reads as zero
  assign old_val = hit_q ? ram_rdata : '0;
  assign sum     = {1'b0, old_val} + {1'b0, weight_q};
  assign sat_val = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  assign ram_we  = cmd_i.wr_add & !skip_q;

  tsh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_q),
    .wdata_i (sat_val),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear_all) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[waddr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      count_q <= old_val;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign count_value_o = count_q;

  assign status_o.kind       = kind_q;
  assign status_o.add_skip   = (single_q && (class_q != target_q)) || (act_taxa_q == '0);
  assign status_o.last_taxon = (taxon_q == '1) ||
                               (({1'b0, taxon_q} + NUM_W'(1)) >= act_taxa_q);
  assign status_o.out_busy   = out_valid_q & !out_ready_i;

`ifndef SYNTH
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_all |=> (valid_q == '0))
    else $error("valid bits not cleared after clear item");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(cmd_i.rd_issue_add))
    else $error("table write without a preceding read of the entry");

  a_no_write_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && cmd_i.load_out))
    else $error("table write and output load in the same cycle");
`endif

endmodule

@@ rtl/tsh_ctrl.sv @@
// controller state machine of the taxon state histogram
// depends on tsh_pkg; drives tsh_datapath through tsh_cmd_t
module tsh_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tsh_pkg::tsh_status_t status_i,
  output tsh_pkg::tsh_cmd_t    cmd_o
);
  import tsh_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (status_i.kind)
          KIND_ADD:  state_d = status_i.add_skip ? ST_IDLE : ST_ADD_RD;
          KIND_READ: state_d = ST_RD_DATA;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_ADD_RD: state_d = ST_ADD_WR;
      ST_ADD_WR: state_d = status_i.last_taxon ? ST_IDLE : ST_ADD_RD;
      ST_RD_DATA: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_DECODE: begin
        case (status_i.kind)
          KIND_ADD:   cmd_o.taxon_clr     = 1'b1;
          KIND_READ:  cmd_o.rd_issue_read = 1'b1;
          KIND_CLEAR: cmd_o.clear_all     = 1'b1;
          default: ;
        endcase
      end
      ST_ADD_RD: cmd_o.rd_issue_add = 1'b1;
      ST_ADD_WR: begin
        cmd_o.wr_add    = 1'b1;
        cmd_o.taxon_inc = !status_i.last_taxon;
      end
      ST_RD_DATA: cmd_o.load_out = !status_i.out_busy;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_wr_follows_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD_WR) |-> ($past(state_q) == ST_ADD_RD))
    else $error("add write step not preceded by its read step");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !status_i.out_busy)
    else $error("output register overwritten while still held");

  a_rd_data_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_RD_DATA) |-> $past(cmd_o.rd_issue_read))
    else $error("read result state entered without a table read");
`endif

endmodule

@@ rtl/taxon_state_histogram_core.sv @@
// Weighted per-taxon state histogram over a 16 x 16 table of saturating
// 32-bit counts held in one single-port-read ram. Items are taken one at a
// time: a clear item drops all valid bits at once (no sweep), a read item
// also waits as long as the output register is still held, and an add
// item does a read-modify-write of one table entry per taxon through the
// ram for N taxa, N being active_taxa capped at 16 (no taxa when the column
// is filtered out by class or no taxa are active). Results sit in an output
// register, so a new item is taken while a read result still waits. After
// reset the table reads as all zero with no startup pass.
// depends on tsh_pkg, tsh_if, tsh_ram, tsh_datapath, tsh_ctrl
module taxon_state_histogram_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tsh_in_if.sink                          item_in,
  tsh_out_if.source                       item_out,
  input  logic                            cfg_we_i,
  input  logic [tsh_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tsh_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import tsh_pkg::*;

  tsh_cmd_t    cmd;
  tsh_status_t status;

  tsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_in.valid),
    .in_ready_o (item_in.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (item_in.kind),
    .site_states_i (item_in.site_states),
    .site_class_i  (item_in.site_class),
    .weight_i      (item_in.weight),
    .read_taxon_i  (item_in.read_taxon),
    .read_state_i  (item_in.read_state),
    .out_ready_i   (item_out.ready),
    .out_valid_o   (item_out.valid),
    .count_value_o (item_out.count_value),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
